/* rtl/cit_pkg.sv */
// Shared types and constants for the compacting item table.
// Used by cit_cell and compacting_item_table; depends on nothing else.
package cit_pkg;

  localparam int ID_W     = 32;
  localparam int QTY_W    = 16;
  localparam int POS_W    = 6;
  localparam int TOTAL_W  = 7;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  // Operation selected by an input item
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_ZERO_QTY  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  // Operation broadcast to every cell while it runs
  typedef struct packed {
    mode_t              mode;
    logic [ID_W-1:0]    id;
    logic [QTY_W-1:0]   qty;
    logic [POS_W-1:0]   pos;
  } query_t;

  // Token that travels down the row of cells, one cell per cycle
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [POS_W-1:0]   pos;
    logic [ID_W-1:0]    id;
    logic [QTY_W-1:0]   qty;
  } link_t;

  // One result item
  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   pos;
    logic [ID_W-1:0]    id;
    logic [QTY_W-1:0]   qty;
    logic [TOTAL_W-1:0] total;
  } result_t;

endpackage

/* rtl/cit_cell.sv */
// One table cell: holds a single entry and one stage of the travelling token.
// Depends on cit_pkg; instantiated in a row by compacting_item_table.
module cit_cell #(
  parameter int INDEX  = 0,
  parameter int FILL_W = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cit_pkg::query_t          query_i,
  input  logic [FILL_W-1:0]        fill_i,
  input  cit_pkg::link_t           link_i,
  input  logic [cit_pkg::ID_W-1:0] nbr_id_i,
  input  logic [cit_pkg::QTY_W-1:0] nbr_qty_i,
  output cit_pkg::link_t           link_o,
  output logic [cit_pkg::ID_W-1:0] ent_id_o,
  output logic [cit_pkg::QTY_W-1:0] ent_qty_o
);
  import cit_pkg::*;

  localparam int CMP_W = (FILL_W > POS_W) ? FILL_W : POS_W;

  logic [ID_W-1:0]  ent_id_r,  ent_id_nxt;
  logic [QTY_W-1:0] ent_qty_r, ent_qty_nxt;
  link_t            link_r,    link_nxt;

  logic live;
  logic at_fill;
  logic at_pos;
  logic hit;
  logic shift;

  assign live    = FILL_W'(INDEX) < fill_i;
  assign at_fill = FILL_W'(INDEX) == fill_i;
  assign at_pos  = CMP_W'(query_i.pos) == CMP_W'(INDEX);

  // Decide whether this cell answers the operation
  always_comb begin
    hit   = 1'b0;
    shift = 1'b0;
    unique case (query_i.mode)
      MODE_APPEND: begin
        hit = at_fill && (query_i.qty != '0);
      end
      MODE_FIND: begin
        hit = live && (ent_id_r == query_i.id);
      end
      MODE_REMOVE: begin
        hit   = live && (ent_id_r == query_i.id) && (ent_qty_r == query_i.qty);
        shift = link_i.valid && live && (link_i.done || hit);
      end
      MODE_READ: begin
        hit = live && at_pos;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // Capture the answer into the token, or pass it on unchanged
  always_comb begin
    link_nxt    = link_i;
    ent_id_nxt  = ent_id_r;
    ent_qty_nxt = ent_qty_r;
    if (link_i.valid && !link_i.done && hit) begin
      link_nxt.done = 1'b1;
      link_nxt.pos  = POS_W'(INDEX);
      if (query_i.mode == MODE_APPEND) begin
        link_nxt.id  = query_i.id;
        link_nxt.qty = query_i.qty;
        ent_id_nxt   = query_i.id;
        ent_qty_nxt  = query_i.qty;
      end else begin
        link_nxt.id  = ent_id_r;
        link_nxt.qty = ent_qty_r;
      end
    end
    // Close the gap left by a removal: take the right-hand neighbour's entry
    if (shift) begin
      ent_id_nxt  = nbr_id_i;
      ent_qty_nxt = nbr_qty_i;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    ent_id_r  <= ent_id_nxt;
    ent_qty_r <= ent_qty_nxt;
  end

  // Advance the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  assign link_o    = link_r;
  assign ent_id_o  = ent_id_r;
  assign ent_qty_o = ent_qty_r;

endmodule

/* rtl/compacting_item_table.sv */
// Top level of the compacting item table: stream ports, controller and cell row.
// Depends on cit_pkg and cit_cell.
//
// Usage
//   Input channel (in_*): one table operation per transfer. in_tuser carries
//   the mode (append, find, remove, read), in_tdata the article id, quantity
//   and read position. Result channel (out_*): exactly one result per
//   operation, status in out_tuser, entry fields and entry count in out_tdata.
//   Entries live in a row of CAPACITY cells; an operation runs as a token that
//   visits one cell per cycle, each cell comparing its entry and, on a
//   removal, taking its right-hand neighbour's entry to close the gap.
// Operation flow
//   The token walks the whole row before the result is registered, and the
//   next operation is taken only once that result has moved into the output
//   register: no new operation is taken while one runs.
// Reset
//   Synchronous active-low rst_n empties the table (entry count zero); cell
//   contents are not cleared, only entries below the count are ever read.
// Back-pressure
//   The result waits in an output register while out_tready is low; a result
//   that finishes while that register is full waits in a hold register, and no
//   new operation is taken until it has moved into the output register.
module compacting_item_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // article_id[31:0], quantity[47:32], position[53:48], zero
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // found_position[5:0], entry_article[37:6],
                                  // entry_quantity[53:38], entry_total[60:54], zero
  output logic [2:0]  out_tuser   // status[2:0]
);
  import cit_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);

  state_t            state_r, state_nxt;
  query_t            qry_r;
  logic              launch_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  result_t           res_comb;
  result_t           hold_r;
  result_t           out_r;
  logic              out_valid_r;

  logic              in_fire;
  logic              out_free;
  logic              load_out;
  logic              load_hold;
  logic              save_hold;
  logic              op_ok;
  logic [FILL_W-1:0] fill_new;

  link_t             link [CAPACITY+1];
  logic [ID_W-1:0]   ent_id  [CAPACITY];
  logic [QTY_W-1:0]  ent_qty [CAPACITY];

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Token launch into the first cell
  always_comb begin
    link[0]       = '0;
    link[0].valid = launch_r;
  end

  // Row of cells, each handing the token and its entry to its neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_W-1:0]  nbr_id;
    logic [QTY_W-1:0] nbr_qty;
    if (g == CAPACITY - 1) begin : g_last
      assign nbr_id  = ent_id[g];
      assign nbr_qty = ent_qty[g];
    end else begin : g_mid
      assign nbr_id  = ent_id[g+1];
      assign nbr_qty = ent_qty[g+1];
    end
    cit_cell #(
      .INDEX  (g),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .query_i   (qry_r),
      .fill_i    (fill_r),
      .link_i    (link[g]),
      .nbr_id_i  (nbr_id),
      .nbr_qty_i (nbr_qty),
      .link_o    (link[g+1]),
      .ent_id_o  (ent_id[g]),
      .ent_qty_o (ent_qty[g])
    );
  end

  // Build the result from the token leaving the last cell
  always_comb begin
    res_comb = '0;
    fill_new = fill_r;
    unique case (qry_r.mode)
      MODE_APPEND: begin
        if (qry_r.qty == '0) begin
          res_comb.status = STAT_ZERO_QTY;
        end else if (link[CAPACITY].done) begin
          res_comb.status = STAT_OK;
          fill_new        = fill_r + FILL_W'(1);
        end else begin
          res_comb.status = STAT_FULL;
        end
      end
      MODE_FIND: begin
        res_comb.status = link[CAPACITY].done ? STAT_OK : STAT_NOT_FOUND;
      end
      MODE_REMOVE: begin
        if (link[CAPACITY].done) begin
          res_comb.status = STAT_OK;
          fill_new        = fill_r - FILL_W'(1);
        end else begin
          res_comb.status = STAT_NOT_FOUND;
        end
      end
      MODE_READ: begin
        res_comb.status = link[CAPACITY].done ? STAT_OK : STAT_RANGE;
      end
      default: begin
        res_comb.status = STAT_NOT_FOUND;
      end
    endcase
    op_ok = res_comb.status == STAT_OK;
    if (op_ok) begin
      res_comb.pos = link[CAPACITY].pos;
      res_comb.id  = link[CAPACITY].id;
      res_comb.qty = link[CAPACITY].qty;
    end
    res_comb.total = TOTAL_W'(fill_new);
  end

  // Controller: next state and strobes
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    load_out  = 1'b0;
    load_hold = 1'b0;
    save_hold = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (link[CAPACITY].valid) begin
          fill_nxt = fill_new;
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            save_hold = 1'b1;
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_hold = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      launch_r <= in_fire;
      if (load_out || load_hold) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: query, hold stage and output stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      qry_r.mode <= mode_t'(in_tuser);
      qry_r.id   <= in_tdata[31:0];
      qry_r.qty  <= in_tdata[47:32];
      qry_r.pos  <= in_tdata[53:48];
    end
    if (save_hold) begin
      hold_r <= res_comb;
    end
    if (load_out) begin
      out_r <= res_comb;
    end else if (load_hold) begin
      out_r <= hold_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {3'b000, out_r.total, out_r.qty, out_r.id, out_r.pos};

  // The token only leaves the row while an operation runs
  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    link[CAPACITY].valid |-> state_r == S_RUN)
    else $error("token left the cell row outside an operation");

  // The entry count never exceeds the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // The entry count moves only when an operation finishes
  a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !link[CAPACITY].valid |=> $stable(fill_r))
    else $error("entry count changed outside operation end");

  // An accepted operation launches exactly one token next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> launch_r && state_r == S_RUN)
    else $error("accepted operation did not launch");

  // A result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !load_out && !load_hold)
    else $error("stalled result overwritten");

endmodule

/* tb/tb_compacting_item_table.sv */
// Self-checking testbench for the compacting item table: directed and random table operations
// over the stream ports, checked against an in-bench model of the entry table.
// Depends on cit_pkg and compacting_item_table.
module tb_compacting_item_table;
  import cit_pkg::*;

  localparam int CAPACITY         = 64;
  localparam int SETTLE_CYCLES    = 2 * CAPACITY + 20;
  localparam int LONG_HOLD_CYCLES = 700;
  localparam int OPS_PER_PHASE    = 205;
  localparam int REPORT_LIMIT     = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;  // article_id[31:0], quantity[47:32], position[53:48], zero
  logic [1:0]  in_tuser   = '0;  // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // found_position[5:0], entry_article[37:6],
                                 // entry_quantity[53:38], entry_total[60:54], zero
  logic [2:0]  out_tuser;        // status[2:0]

  compacting_item_table #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Operations waiting to be offered, results waiting to come back
  query_t     queued_ops[$];
  result_t    awaited_results[$];
  idle_mode_t idle_mode     = IDLE_NONE;
  bit         op_taken      = 1'b0;
  bit         long_hold_req = 1'b0;
  bit         long_hold_done = 1'b0;
  int         hold_left     = 0;
  int         fault_count   = 0;

  // Shadow copy of the entry table
  logic [ID_W-1:0]  shadow_ids  [CAPACITY];
  logic [QTY_W-1:0] shadow_qtys [CAPACITY];
  int               shadow_count = 0;

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #15000000;
    $display("== FAIL ==");
    $finish;
  end

  // Apply one operation to the shadow table and return the result it yields
  function automatic result_t apply_table_op(query_t op);
    result_t r;
    int      hit;
    r        = '0;
    r.status = STAT_OK;
    hit      = -1;
    case (op.mode)
      MODE_APPEND: begin
        // zero quantity is checked ahead of a full table
        if (op.qty == '0) begin
          r.status = STAT_ZERO_QTY;
        end else if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_ids[shadow_count]  = op.id;
          shadow_qtys[shadow_count] = op.qty;
          r.pos = POS_W'(shadow_count);
          r.id  = op.id;
          r.qty = op.qty;
          shadow_count++;
        end
      end
      MODE_FIND: begin
        for (int i = 0; i < shadow_count; i++)
          if (hit < 0 && shadow_ids[i] == op.id) hit = i;
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.pos = POS_W'(hit);
          r.id  = shadow_ids[hit];
          r.qty = shadow_qtys[hit];
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < shadow_count; i++)
          if (hit < 0 && shadow_ids[i] == op.id && shadow_qtys[i] == op.qty) hit = i;
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.pos = POS_W'(hit);
          r.id  = shadow_ids[hit];
          r.qty = shadow_qtys[hit];
          // close the gap left by the removed entry
          for (int k = hit; k + 1 < shadow_count; k++) begin
            shadow_ids[k]  = shadow_ids[k + 1];
            shadow_qtys[k] = shadow_qtys[k + 1];
          end
          shadow_count--;
        end
      end
      default: begin
        if (int'(op.pos) >= shadow_count) begin
          r.status = STAT_RANGE;
        end else begin
          r.pos = op.pos;
          r.id  = shadow_ids[op.pos];
          r.qty = shadow_qtys[op.pos];
        end
      end
    endcase
    r.total = TOTAL_W'(shadow_count);
    return r;
  endfunction

  function automatic void push_op(mode_t m, logic [ID_W-1:0] id, logic [QTY_W-1:0] qty,
                                  logic [POS_W-1:0] pos);
    query_t op;
    op.mode = m;
    op.id   = id;
    op.qty  = qty;
    op.pos  = pos;
    queued_ops.push_back(op);
  endfunction

  // Small pools of ids and quantities so that finds and removes hit often
  function automatic logic [ID_W-1:0] pool_id(int k);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0001;
      3:       return 32'h5A5A_A5A5;
      4:       return 32'h0000_0001;
      5:       return 32'h7FFF_FFFE;
      6:       return 32'hC0DE_0042;
      default: return 32'h1234_5678;
    endcase
  endfunction

  function automatic logic [QTY_W-1:0] pool_qty(int k);
    case (k)
      0:       return 16'h0001;
      1:       return 16'h0007;
      2:       return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Random operation, weighted towards growing or towards draining the table
  function automatic query_t random_op(bit filling);
    query_t op;
    int     pick;
    pick = $urandom_range(99);
    if (filling) begin
      if (pick < 55)      op.mode = MODE_APPEND;
      else if (pick < 70) op.mode = MODE_FIND;
      else if (pick < 80) op.mode = MODE_REMOVE;
      else                op.mode = MODE_READ;
    end else begin
      if (pick < 15)      op.mode = MODE_APPEND;
      else if (pick < 30) op.mode = MODE_FIND;
      else if (pick < 75) op.mode = MODE_REMOVE;
      else                op.mode = MODE_READ;
    end
    op.id = ($urandom_range(3) == 0) ? ID_W'($urandom()) : pool_id($urandom_range(7));
    pick  = $urandom_range(99);
    if (pick < 5)       op.qty = '0;
    else if (pick < 75) op.qty = pool_qty($urandom_range(3));
    else                op.qty = QTY_W'($urandom());
    op.pos = $urandom_range(1) ? POS_W'($urandom_range(15)) : POS_W'($urandom());
    return op;
  endfunction

  function automatic bit idles_now(bit sender_side);
    case (idle_mode)
      IDLE_SENDER:   return sender_side && ($urandom_range(99) < 86);
      IDLE_RECEIVER: return !sender_side && ($urandom_range(99) < 86);
      IDLE_BOTH:     return $urandom_range(99) < 20;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic wait_until_settled();
    while (queued_ops.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_fault(string what, result_t want, result_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("%0t %s: expected st=%0d pos=%0d id=%h qty=%h total=%0d, got st=%0d pos=%0d id=%h qty=%h total=%0d",
               $time, what, want.status, want.pos, want.id, want.qty, want.total,
               got.status, got.pos, got.id, got.qty, got.total);
  endtask

  // Offer queued operations on the falling edge, holding each until its transfer
  always @(negedge clk) begin : op_driver
    query_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || op_taken) begin
      if (queued_ops.size() != 0 && !idles_now(1'b1)) begin
        op = queued_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, op.pos, op.qty, op.id};
        in_tuser  <= op.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Drive out_tready, with one long hold-off on request
  always @(negedge clk) begin : result_sink
    if (long_hold_req && !long_hold_done) begin
      hold_left      = LONG_HOLD_CYCLES;
      long_hold_done = 1'b1;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idles_now(1'b0);
    end
  end

  // Predict on each input transfer, check each result transfer
  always @(posedge clk) begin : table_monitor
    query_t  op;
    result_t want;
    result_t got;
    op_taken = rst_n && in_tvalid && in_tready;
    if (op_taken) begin
      op.id   = in_tdata[31:0];
      op.qty  = in_tdata[47:32];
      op.pos  = in_tdata[53:48];
      op.mode = mode_t'(in_tuser);
      awaited_results.push_back(apply_table_op(op));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.pos    = out_tdata[5:0];
      got.id     = out_tdata[37:6];
      got.qty    = out_tdata[53:38];
      got.total  = out_tdata[60:54];
      if (awaited_results.size() == 0) begin
        report_fault("unexpected result", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.pos !== want.pos || got.id !== want.id ||
            got.qty !== want.qty || got.total !== want.total)
          report_fault("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: out-of-range read, misses, zero quantity
    push_op(MODE_READ,   32'h0000_0000, 16'h0000, 6'd0);
    push_op(MODE_FIND,   32'h0000_0000, 16'h0000, 6'd0);
    push_op(MODE_REMOVE, 32'h0000_0000, 16'h0001, 6'd0);
    push_op(MODE_APPEND, 32'hFFFF_FFFF, 16'h0000, 6'd63);
    // Extremes of id and quantity
    push_op(MODE_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 6'd0);
    push_op(MODE_APPEND, 32'h0000_0000, 16'h0001, 6'd0);
    push_op(MODE_APPEND, 32'h1234_5678, 16'h8000, 6'd0);
    push_op(MODE_FIND,   32'h0000_0000, 16'hFFFF, 6'd63);
    push_op(MODE_FIND,   32'hDEAD_BEEF, 16'h0000, 6'd0);
    // Id matches but quantity does not, then a true removal at the head
    push_op(MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFE, 6'd0);
    push_op(MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 6'd0);
    push_op(MODE_READ,   32'h0000_0000, 16'h0000, 6'd0);
    push_op(MODE_READ,   32'hFFFF_FFFF, 16'hFFFF, 6'd1);
    push_op(MODE_READ,   32'h0000_0000, 16'h0000, 6'd2);
    push_op(MODE_READ,   32'h0000_0000, 16'h0000, 6'd63);
    // Duplicate id: find returns the first, remove needs both keys
    push_op(MODE_APPEND, 32'h0000_0000, 16'h0002, 6'd0);
    push_op(MODE_FIND,   32'h0000_0000, 16'h0000, 6'd0);
    push_op(MODE_REMOVE, 32'h0000_0000, 16'h0002, 6'd0);
    push_op(MODE_REMOVE, 32'h1234_5678, 16'h8000, 6'd0);
    push_op(MODE_READ,   32'h0000_0000, 16'h0000, 6'd0);
    wait_until_settled();

    // Random phases: grow to full, then drain, under each idling pattern
    for (int p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
      idle_mode = idle_mode_t'(p);
      if (p == IDLE_NONE) long_hold_req = 1'b1;
      repeat (OPS_PER_PHASE) queued_ops.push_back(random_op(1'b1));
      repeat (OPS_PER_PHASE) queued_ops.push_back(random_op(1'b0));
      wait_until_settled();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cit_pkg.sv
rtl/cit_cell.sv
rtl/compacting_item_table.sv
tb/tb_compacting_item_table.sv
